[hdl/pcmts_pkg.sv]
// ----------------------------------------------------------------------------
// pcmts_pkg
// Shared widths, constants and types of the PCM packet timestamp builder.
// ----------------------------------------------------------------------------
package pcmts_pkg;

	localparam int RATE_BITS_DEF = 20;

	localparam int POS_W     = 64;
	localparam int TICK_W    = 64;
	localparam int FRAMES_W  = 32;
	localparam int NS_W      = 63;
	localparam int NUM_W     = 64;	// 2*frames*1e9 + rate, below 2^64
	localparam int PROD_W    = 62;	// frames*1e9, below 2^62
	localparam int TS_FULL_W = 71;	// ticks*100 before saturation
	localparam int SPS_W     = 30;

	localparam logic [NS_W-1:0]   NS_MAX     = '1;
	localparam logic [6:0]        TICK_NS    = 7'd100;
	localparam logic [TICK_W-1:0] TICK_LIMIT = TICK_W'(NS_MAX) / TICK_W'(100);
	localparam logic [SPS_W-1:0]  NS_PER_SEC = 30'd1000000000;
	localparam logic [31:0]       RATE_RESET = 32'd48000;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FRAMES = 2'd1,
		ST_NO_RATE   = 2'd2
	} status_t;

	// fields that ride alongside the divider
	typedef struct packed {
		status_t               status;
		logic [POS_W-1:0]      pos;
		logic [TICK_W-1:0]     ticks;
		logic [FRAMES_W-1:0]   frames;
		logic [NS_W-1:0]       ts_ns;
	} side_t;

	typedef struct packed {
		status_t               status;
		logic [POS_W-1:0]      frame_position_out;
		logic [TICK_W-1:0]     counter_time_out;
		logic [FRAMES_W-1:0]   frames_out;
		logic [NS_W-1:0]       timestamp_ns;
		logic [NS_W-1:0]       packet_len_ns;
	} result_t;

endpackage

[hdl/pcmts_if.sv]
// ----------------------------------------------------------------------------
// pcmts_if
// Valid/ready channels for packet items and result items.
// ----------------------------------------------------------------------------
interface pcmts_in_if;
	logic                           valid;
	logic                           ready;
	logic [pcmts_pkg::POS_W-1:0]    device_frame_position;
	logic [pcmts_pkg::TICK_W-1:0]   counter_time_100ns;
	logic [pcmts_pkg::FRAMES_W-1:0] packet_frames;

	modport source(output valid, device_frame_position, counter_time_100ns, packet_frames,
		input ready);
	modport sink(input valid, device_frame_position, counter_time_100ns, packet_frames,
		output ready);
endinterface

interface pcmts_out_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     status;
	logic [pcmts_pkg::POS_W-1:0]    frame_position_out;
	logic [pcmts_pkg::TICK_W-1:0]   counter_time_out;
	logic [pcmts_pkg::FRAMES_W-1:0] frames_out;
	logic [pcmts_pkg::NS_W-1:0]     timestamp_ns;
	logic [pcmts_pkg::NS_W-1:0]     packet_len_ns;

	modport source(output valid, status, frame_position_out, counter_time_out, frames_out,
		timestamp_ns, packet_len_ns, input ready);
	modport sink(input valid, status, frame_position_out, counter_time_out, frames_out,
		timestamp_ns, packet_len_ns, output ready);
endinterface

[hdl/pcmts_front.sv]
// ----------------------------------------------------------------------------
// pcmts_front
// Two front stages: status, timestamp scaling, frame product, then the
// rounded dividend 2*frames*1e9 + rate.
// ----------------------------------------------------------------------------
module pcmts_front #(
	parameter int RATE_BITS = pcmts_pkg::RATE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           ce,
	input  logic                           in_valid,
	input  logic [pcmts_pkg::POS_W-1:0]    pos,
	input  logic [pcmts_pkg::TICK_W-1:0]   ticks,
	input  logic [pcmts_pkg::FRAMES_W-1:0] frames,
	input  logic [RATE_BITS-1:0]           rate,
	output logic                           valid_s2,
	output logic [pcmts_pkg::NUM_W-1:0]    num_s2,
	output pcmts_pkg::side_t               side_s2
);

	logic                                 valid_s1;
	logic [pcmts_pkg::PROD_W-1:0]         prod_s1;
	pcmts_pkg::side_t                     side_s1;
	pcmts_pkg::side_t                     side_d;
	logic [pcmts_pkg::TS_FULL_W-1:0]      ts_full;

	assign ts_full = pcmts_pkg::TS_FULL_W'(ticks) * pcmts_pkg::TS_FULL_W'(pcmts_pkg::TICK_NS);

	always_comb begin
		side_d = '0;
		if (frames == '0) begin
			side_d.status = pcmts_pkg::ST_NO_FRAMES;
		end else if (rate == '0) begin
			side_d.status = pcmts_pkg::ST_NO_RATE;
		end else begin
			side_d.status = pcmts_pkg::ST_OK;
			side_d.pos    = pos;
			side_d.ticks  = ticks;
			side_d.frames = frames;
			side_d.ts_ns  = (ticks > pcmts_pkg::TICK_LIMIT) ? pcmts_pkg::NS_MAX
				: ts_full[pcmts_pkg::NS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			prod_s1 <= pcmts_pkg::PROD_W'(frames) * pcmts_pkg::PROD_W'(pcmts_pkg::NS_PER_SEC);
			side_s1 <= side_d;
			// half-up rounding: (2*num + rate) / (2*rate)
			num_s2  <= pcmts_pkg::NUM_W'({prod_s1, 1'b0}) + pcmts_pkg::NUM_W'(rate);
			side_s2 <= side_s1;
		end
	end

endmodule

[hdl/pcmts_divider.sv]
// ----------------------------------------------------------------------------
// pcmts_divider
// Restoring divider, one quotient bit per pipeline stage. The dividend
// shifts out at the top while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module pcmts_divider #(
	parameter int RATE_BITS = pcmts_pkg::RATE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ce,
	input  logic                        in_valid,
	input  logic [pcmts_pkg::NUM_W-1:0] in_num,
	input  pcmts_pkg::side_t            in_side,
	input  logic [RATE_BITS+1:0]        divisor,
	output logic                        out_valid,
	output logic [pcmts_pkg::NUM_W-1:0] out_quo,
	output pcmts_pkg::side_t            out_side
);

	localparam int REM_W  = RATE_BITS + 1;
	localparam int STAGES = pcmts_pkg::NUM_W;

	logic                        vld_s  [STAGES];
	logic [REM_W-1:0]            rem_s  [STAGES];
	logic [pcmts_pkg::NUM_W-1:0] dq_s   [STAGES];
	pcmts_pkg::side_t            side_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic                        vld_in;
		logic [REM_W-1:0]            rem_in;
		logic [pcmts_pkg::NUM_W-1:0] dq_in;
		pcmts_pkg::side_t            side_in;
		logic [REM_W:0]              part;
		logic [REM_W:0]              trial;
		logic                        take;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = '0;
			assign dq_in   = in_num;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign dq_in   = dq_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign part  = {rem_in, dq_in[pcmts_pkg::NUM_W-1]};
		assign take  = (part >= divisor);
		assign trial = part - divisor;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (ce) begin
				vld_s[k] <= vld_in;
			end
		end

		// remainder stays below the divisor, so it fits REM_W bits
		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k]  <= take ? trial[REM_W-1:0] : part[REM_W-1:0];
				dq_s[k]   <= {dq_in[pcmts_pkg::NUM_W-2:0], take};
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign out_quo   = dq_s[STAGES-1];
	assign out_side  = side_s[STAGES-1];

endmodule

[hdl/pcmts_out_buf.sv]
// ----------------------------------------------------------------------------
// pcmts_out_buf
// Two-entry output buffer. Full only when both entries hold an item, so
// the pipeline keeps moving while one result waits at the output.
// ----------------------------------------------------------------------------
module pcmts_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pcmts_pkg::result_t push_data,
	input  logic               pop,
	output logic               not_empty,
	output logic               full,
	output pcmts_pkg::result_t head
);

	logic [1:0]         count_q;
	pcmts_pkg::result_t ent_q [2];

	assign not_empty = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign head      = ent_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (count_q == 2'd1) begin
				ent_q[0] <= push_data;
			end else begin
				ent_q[0] <= ent_q[1];
				ent_q[1] <= push_data;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				ent_q[0] <= push_data;
			end else begin
				ent_q[1] <= push_data;
			end
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
		end
	end

endmodule

[hdl/pcmts_top_dummy_never.sv]
// ----------------------------------------------------------------------------
// pcmts_sat
// Final result assembly: duration saturation and zeroing on error.
// ----------------------------------------------------------------------------
module pcmts_sat (
	input  logic [pcmts_pkg::NUM_W-1:0] quo,
	input  pcmts_pkg::side_t            side,
	output pcmts_pkg::result_t          result
);

	always_comb begin
		result                    = '0;
		result.status             = side.status;
		result.frame_position_out = side.pos;
		result.counter_time_out   = side.ticks;
		result.frames_out         = side.frames;
		result.timestamp_ns       = side.ts_ns;
		if (side.status == pcmts_pkg::ST_OK) begin
			result.packet_len_ns = quo[pcmts_pkg::NUM_W-1] ? pcmts_pkg::NS_MAX
				: quo[pcmts_pkg::NS_W-1:0];
		end
	end

endmodule

[hdl/pcm_packet_timestamp_builder.sv]
// ----------------------------------------------------------------------------
// pcm_packet_timestamp_builder
// Throughput: one item per cycle while the output buffer is not full; depth
// set by the 64-stage divider that yields one quotient bit per stage, after
// two front stages.
// Reset: clears all valid bits and the output buffer; the sample rate
// register returns to 48000.
// ----------------------------------------------------------------------------
module pcm_packet_timestamp_builder #(
	parameter int RATE_BITS = pcmts_pkg::RATE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [RATE_BITS-1:0] cfg_wdata,
	pcmts_in_if.sink             pkt_in,
	pcmts_out_if.source          pkt_out
);

	logic                        ce;
	logic [RATE_BITS-1:0]        rate_q;
	logic [RATE_BITS+1:0]        divisor;
	logic                        front_valid;
	logic [pcmts_pkg::NUM_W-1:0] front_num;
	pcmts_pkg::side_t            front_side;
	logic                        div_valid;
	logic [pcmts_pkg::NUM_W-1:0] div_quo;
	pcmts_pkg::side_t            div_side;
	pcmts_pkg::result_t          result;
	pcmts_pkg::result_t          head;
	logic                        buf_full;
	logic                        buf_not_empty;
	logic                        pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_BITS'(pcmts_pkg::RATE_RESET);
		end else if (cfg_wen) begin
			rate_q <= cfg_wdata;
		end
	end

	// whole pipeline moves unless both output entries are taken
	assign ce           = !buf_full;
	assign pkt_in.ready = ce;
	assign divisor      = {1'b0, rate_q, 1'b0};
	assign pop          = pkt_out.valid && pkt_out.ready;

	pcmts_front #(.RATE_BITS(RATE_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (pkt_in.valid),
		.pos      (pkt_in.device_frame_position),
		.ticks    (pkt_in.counter_time_100ns),
		.frames   (pkt_in.packet_frames),
		.rate     (rate_q),
		.valid_s2 (front_valid),
		.num_s2   (front_num),
		.side_s2  (front_side)
	);

	pcmts_divider #(.RATE_BITS(RATE_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (front_valid),
		.in_num    (front_num),
		.in_side   (front_side),
		.divisor   (divisor),
		.out_valid (div_valid),
		.out_quo   (div_quo),
		.out_side  (div_side)
	);

	pcmts_sat u_sat (
		.quo    (div_quo),
		.side   (div_side),
		.result (result)
	);

	pcmts_out_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (div_valid && ce),
		.push_data (result),
		.pop       (pop),
		.not_empty (buf_not_empty),
		.full      (buf_full),
		.head      (head)
	);

	assign pkt_out.valid              = buf_not_empty;
	assign pkt_out.status             = head.status;
	assign pkt_out.frame_position_out = head.frame_position_out;
	assign pkt_out.counter_time_out   = head.counter_time_out;
	assign pkt_out.frames_out         = head.frames_out;
	assign pkt_out.timestamp_ns       = head.timestamp_ns;
	assign pkt_out.packet_len_ns      = head.packet_len_ns;

	// an item leaving the divider lands in the buffer
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && !buf_full |=> pkt_out.valid)
		else $error("divider item not captured by output buffer");

	// a full buffer with no pop freezes the divider output
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		buf_full && !pkt_out.ready |=> $stable(div_valid) && $stable(div_quo))
		else $error("divider moved during stall");

	// error results carry no numbers
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_out.valid && (pkt_out.status != pcmts_pkg::ST_OK) |->
		(pkt_out.packet_len_ns == '0) && (pkt_out.timestamp_ns == '0) &&
		(pkt_out.frames_out == '0))
		else $error("error result with non-zero fields");

	// an ok result always has frames
	a_ok_frames: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_out.valid && (pkt_out.status == pcmts_pkg::ST_OK) |-> (pkt_out.frames_out != '0))
		else $error("ok result with zero frames");

endmodule
